/* rtl/dim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_pkg
// Shared types and fixed field widths for the diagonal interval merge block.
// ----------------------------------------------------------------------------
package dim_pkg;

    // Width of every coordinate and diagonal field on the ports
    localparam int FIELD_W  = 16;
    // diag, lb, rb packed from the lowest bit up
    localparam int TDATA_W  = 3 * FIELD_W;
    localparam int M_TUSER_W = 1;

    // Broadcast control from the top level to every slot cell
    typedef struct packed {
        logic shift;   // flush: every cell takes its upper neighbour's content
        logic ins;     // a bound is presented this cycle
        logic append;  // the bound hit no slot, first empty cell takes it
    } dim_ctrl_t;

endpackage

/* rtl/dim_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_cell
// One slot of the interval store: compares the broadcast bound, widens on a
// hit, loads on append when it is the first empty cell, and shifts down on
// flush.
// ----------------------------------------------------------------------------
module dim_cell #(
    parameter int CW = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dim_pkg::dim_ctrl_t  ctrl,
    input  logic [CW-1:0]       bnd_lb,
    input  logic [CW-1:0]       bnd_rb,
    input  logic                prev_occ,
    input  logic                nxt_occ,
    input  logic [CW-1:0]       nxt_lb,
    input  logic [CW-1:0]       nxt_rb,
    output logic                occ,
    output logic [CW-1:0]       lb,
    output logic [CW-1:0]       rb,
    output logic                hit
);

    logic          occ_reg, occ_next;
    logic [CW-1:0] lb_reg, lb_next;
    logic [CW-1:0] rb_reg, rb_next;

    // closed intervals: touching counts as a hit
    assign hit = occ_reg && (bnd_lb <= rb_reg) && (lb_reg <= bnd_rb);

    always_comb begin
        occ_next = occ_reg;
        lb_next  = lb_reg;
        rb_next  = rb_reg;
        if (ctrl.shift) begin
            occ_next = nxt_occ;
            lb_next  = nxt_lb;
            rb_next  = nxt_rb;
        end else if (ctrl.ins) begin
            if (hit) begin
                if (bnd_lb < lb_reg) lb_next = bnd_lb;
                if (bnd_rb > rb_reg) rb_next = bnd_rb;
            end else if (ctrl.append && !occ_reg && prev_occ) begin
                occ_next = 1'b1;
                lb_next  = bnd_lb;
                rb_next  = bnd_rb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        lb_reg <= lb_next;
        rb_reg <= rb_next;
    end

    assign occ = occ_reg;
    assign lb  = lb_reg;
    assign rb  = rb_reg;

endmodule

/* rtl/diagonal_interval_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_interval_merge
// Merges interval bounds per antidiagonal in a row of slot cells and emits
// the merged intervals in insertion order on a diagonal change or at the end
// of input.
// ----------------------------------------------------------------------------
// A bound on the current diagonal (or an ignored one) is taken directly:
// all SLOTS cells compare it in parallel and either widen or append. A bound
// on a new diagonal first flushes the store, at one output transaction per
// cycle while the master side does not stall, and is then inserted from the
// pending registers. A bound with end_of_input adds a further flush. The
// flush rate is set by the cell chain, which shifts one interval per cycle
// down to cell 0, where the output is taken, while m_tready is high.
// Input is held off while a flush is under way.
// ----------------------------------------------------------------------------
module diagonal_interval_merge #(
    parameter int SLOTS      = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: diag_limit
    input  logic                          cfg_wr_en,
    input  logic [dim_pkg::FIELD_W-1:0]   cfg_wr_data,
    // input bounds
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dim_pkg::TDATA_W-1:0]   s_tdata,   // bound_diag, bound_lb, bound_rb
    input  logic                          s_tlast,   // end_of_input
    // merged intervals
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dim_pkg::TDATA_W-1:0]   m_tdata,   // out_diag, out_lb, out_rb
    output logic                          m_tlast,   // last_of_run
    output logic [dim_pkg::M_TUSER_W-1:0] m_tuser    // overflow
);

    localparam int FW = dim_pkg::FIELD_W;
    localparam int CW = (COORD_BITS < FW) ? COORD_BITS : FW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FLUSH  = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [FW-1:0] limit_reg, limit_next;
    logic [FW-1:0] cur_diag_reg, cur_diag_next;
    logic          diag_valid_reg, diag_valid_next;
    logic          dropped_reg, dropped_next;
    logic          pend_ins_reg, pend_ins_next;
    logic          pend_last_reg, pend_last_next;
    logic [FW-1:0] pend_diag_reg, pend_diag_next;
    logic [CW-1:0] pend_lb_reg, pend_lb_next;
    logic [CW-1:0] pend_rb_reg, pend_rb_next;

    logic [FW-1:0] in_diag;
    logic [CW-1:0] in_lb, in_rb;
    logic          s_acc, d_ok, d_change;

    dim_pkg::dim_ctrl_t ctrl;
    logic [CW-1:0] bnd_lb, bnd_rb;

    logic          occ_w   [SLOTS];
    logic [CW-1:0] lb_w    [SLOTS];
    logic [CW-1:0] rb_w    [SLOTS];
    logic [SLOTS-1:0] hit_w;
    logic          prev_occ_w [SLOTS];
    logic          nxt_occ_w  [SLOTS];
    logic [CW-1:0] nxt_lb_w   [SLOTS];
    logic [CW-1:0] nxt_rb_w   [SLOTS];
    logic          any_hit, full;

    assign in_diag = s_tdata[FW-1:0];
    assign in_lb   = s_tdata[FW +: CW];
    assign in_rb   = s_tdata[2*FW +: CW];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign d_ok     = (in_diag < limit_reg);
    assign d_change = d_ok && diag_valid_reg && (in_diag != cur_diag_reg);

    assign any_hit = |hit_w;
    assign full    = occ_w[SLOTS-1];

    assign m_tvalid = (state_reg == ST_FLUSH) && occ_w[0];
    assign m_tdata  = {FW'(rb_w[0]), FW'(lb_w[0]), cur_diag_reg};
    assign m_tlast  = !nxt_occ_w[0];
    assign m_tuser  = dropped_reg;

    always_comb begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        cur_diag_next   = cur_diag_reg;
        diag_valid_next = diag_valid_reg;
        dropped_next    = dropped_reg;
        pend_ins_next   = pend_ins_reg;
        pend_last_next  = pend_last_reg;
        pend_diag_next  = pend_diag_reg;
        pend_lb_next    = pend_lb_reg;
        pend_rb_next    = pend_rb_reg;
        ctrl            = '0;
        bnd_lb          = in_lb;
        bnd_rb          = in_rb;

        if (cfg_wr_en) limit_next = cfg_wr_data;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (d_change) begin
                        // flush the old diagonal first, insert afterwards
                        pend_ins_next  = 1'b1;
                        pend_last_next = s_tlast;
                        pend_diag_next = in_diag;
                        pend_lb_next   = in_lb;
                        pend_rb_next   = in_rb;
                        state_next     = ST_FLUSH;
                    end else begin
                        if (d_ok) begin
                            ctrl.ins        = 1'b1;
                            cur_diag_next   = in_diag;
                            diag_valid_next = 1'b1;
                        end
                        if (s_tlast) begin
                            pend_ins_next = 1'b0;
                            state_next    = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                ctrl.shift = m_tvalid && m_tready;
                if (!occ_w[0]) begin
                    diag_valid_next = 1'b0;
                    dropped_next    = 1'b0;
                    pend_ins_next   = 1'b0;
                    state_next      = pend_ins_reg ? ST_INSERT : ST_IDLE;
                end
            end
            ST_INSERT: begin
                ctrl.ins        = 1'b1;
                bnd_lb          = pend_lb_reg;
                bnd_rb          = pend_rb_reg;
                cur_diag_next   = pend_diag_reg;
                diag_valid_next = 1'b1;
                state_next      = pend_last_reg ? ST_FLUSH : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ctrl.append = ctrl.ins && !any_hit;
        if (ctrl.append && full) dropped_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= {FW{1'b1}};
            cur_diag_reg   <= '0;
            diag_valid_reg <= 1'b0;
            dropped_reg    <= 1'b0;
            pend_ins_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            cur_diag_reg   <= cur_diag_next;
            diag_valid_reg <= diag_valid_next;
            dropped_reg    <= dropped_next;
            pend_ins_reg   <= pend_ins_next;
        end
        pend_last_reg <= pend_last_next;
        pend_diag_reg <= pend_diag_next;
        pend_lb_reg   <= pend_lb_next;
        pend_rb_reg   <= pend_rb_next;
    end

    // slot chain: cell 0 is the oldest entry and faces the output
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign prev_occ_w[k] = 1'b1;
        end else begin : g_mid
            assign prev_occ_w[k] = occ_w[k-1];
        end
        if (k == SLOTS-1) begin : g_top
            assign nxt_occ_w[k] = 1'b0;
            assign nxt_lb_w[k]  = '0;
            assign nxt_rb_w[k]  = '0;
        end else begin : g_link
            assign nxt_occ_w[k] = occ_w[k+1];
            assign nxt_lb_w[k]  = lb_w[k+1];
            assign nxt_rb_w[k]  = rb_w[k+1];
        end

        dim_cell #(
            .CW (CW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .bnd_lb   (bnd_lb),
            .bnd_rb   (bnd_rb),
            .prev_occ (prev_occ_w[k]),
            .nxt_occ  (nxt_occ_w[k]),
            .nxt_lb   (nxt_lb_w[k]),
            .nxt_rb   (nxt_rb_w[k]),
            .occ      (occ_w[k]),
            .lb       (lb_w[k]),
            .rb       (rb_w[k]),
            .hit      (hit_w[k])
        );
    end

endmodule

/* rtl/dim_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_checker
// Port-level checks for the diagonal interval merge block, bound to the top.
// ----------------------------------------------------------------------------
module dim_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dim_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [dim_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result transaction holds its payload
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    // input is held off for the whole of a flush
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted during a flush");

    // the final interval of a run leaves the store empty
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after end of run");

    // reset empties the store and reopens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("bad state after reset");

endmodule

bind diagonal_interval_merge dim_checker u_dim_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* dv/tb_diagonal_interval_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diagonal_interval_merge
// Self-checking bench for the diagonal interval merge block. A queue-fed
// driver offers bounds on the slave side and a local merge model predicts the
// emitted intervals. A monitor checks each master-side transaction against the
// oldest prediction. diag_limit is swept between phases, with random idling
// on both sides and one long master-side hold-off.
// ----------------------------------------------------------------------------
module tb_diagonal_interval_merge;

    localparam int FIELD_W      = dim_pkg::FIELD_W;
    localparam int TDATA_W      = dim_pkg::TDATA_W;
    localparam int M_TUSER_W    = dim_pkg::M_TUSER_W;

    localparam int SLOTS        = 32;
    localparam int COORD_BITS   = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic [FIELD_W-1:0] diag;
        logic [FIELD_W-1:0] lb;
        logic [FIELD_W-1:0] rb;
        logic               eoi;
    } bound_t;

    typedef struct {
        logic [FIELD_W-1:0] diag;
        logic [FIELD_W-1:0] lb;
        logic [FIELD_W-1:0] rb;
        logic               last;
        logic               ovf;
    } interval_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata     = '0;  // bound_diag, bound_lb, bound_rb
    logic                 s_tlast     = 1'b0; // end_of_input
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;           // out_diag, out_lb, out_rb
    logic                 m_tlast;           // last_of_run
    logic [M_TUSER_W-1:0] m_tuser;           // overflow

    bound_t    bound_q[$];
    interval_t merged_q[$];
    int        mismatches    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_armed    = 1'b0;

    // merge model state
    logic [FIELD_W-1:0] st_lb[SLOTS];
    logic [FIELD_W-1:0] st_rb[SLOTS];
    int                 st_count   = 0;
    logic [FIELD_W-1:0] st_diag    = '0;
    bit                 st_live    = 1'b0;
    bit                 st_dropped = 1'b0;
    logic [FIELD_W-1:0] limit_q    = '1;

    diagonal_interval_merge #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic emit_store();
        interval_t iv;
        for (int k = 0; k < st_count; k++) begin
            iv.diag = st_diag;
            iv.lb   = st_lb[k];
            iv.rb   = st_rb[k];
            iv.last = (k == st_count - 1);
            iv.ovf  = st_dropped;
            merged_q.push_back(iv);
        end
        st_count   = 0;
        st_live    = 1'b0;
        st_dropped = 1'b0;
    endtask

    task automatic merge_bound(input bound_t b);
        bit hit;
        hit = 1'b0;
        if (b.diag < limit_q) begin
            // any change of diagonal, up or down, flushes first
            if (st_live && b.diag != st_diag)
                emit_store();
            st_diag = b.diag;
            st_live = 1'b1;
            // every touching slot widens on its own; slots are never combined
            for (int k = 0; k < st_count; k++) begin
                if (b.lb <= st_rb[k] && st_lb[k] <= b.rb) begin
                    if (b.lb < st_lb[k]) st_lb[k] = b.lb;
                    if (b.rb > st_rb[k]) st_rb[k] = b.rb;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (st_count < SLOTS) begin
                    st_lb[st_count] = b.lb;
                    st_rb[st_count] = b.rb;
                    st_count++;
                end else begin
                    st_dropped = 1'b1;
                end
            end
        end
        if (b.eoi)
            emit_store();
    endtask

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic push_bound(input int d, input int lb, input int rb, input bit eoi);
        bound_t b;
        b.diag = d[FIELD_W-1:0];
        b.lb   = lb[FIELD_W-1:0];
        b.rb   = rb[FIELD_W-1:0];
        b.eoi  = eoi;
        bound_q.push_back(b);
    endtask

    // Runs of bounds per diagonal with random content, plus store overflows,
    // steps back, jumps and the odd fully random transaction.
    task automatic gen_runs(input int n, input int lo, input int hi);
        int made;
        int diag;
        int kind;
        int cnt;
        int base;
        int lb;
        int rb;
        int t;
        bit eoi;
        made = 0;
        diag = lo;
        while (made < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
                diag = $urandom_range(lo, diag);
            else if (kind < 14)
                diag = $urandom_range(lo, hi);
            else
                diag = diag + $urandom_range(1, 4);
            if (diag > hi)
                diag = lo;
            if (kind >= 14 && kind < 22) begin
                // more disjoint bounds than slots
                cnt  = SLOTS + $urandom_range(1, 3);
                base = $urandom_range(0, 1000);
                for (int i = 0; i < cnt; i++)
                    push_bound(diag, base + 3 * i, base + 3 * i + 1, 1'b0);
                made += cnt;
            end else if (kind >= 22 && kind < 27) begin
                push_bound($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
                made++;
            end else begin
                cnt  = $urandom_range(1, 6);
                base = $urandom_range(0, 200);
                for (int i = 0; i < cnt; i++) begin
                    lb = base + $urandom_range(0, 40);
                    rb = lb + $urandom_range(0, 12);
                    t  = $urandom_range(0, 19);
                    if (t == 0) begin
                        rb = lb;
                        lb = lb + $urandom_range(1, 12);
                    end else if (t == 1) begin
                        lb = $urandom_range(0, 65535);
                        rb = $urandom_range(0, 65535);
                    end
                    eoi = (i == cnt - 1) && ($urandom_range(0, 9) == 0);
                    push_bound(diag, lb, rb, eoi);
                end
                made += cnt;
            end
        end
        push_bound(lo, 0, 0, 1'b1);
    endtask

    task automatic set_limit(input logic [FIELD_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_q = v;
        @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        while (bound_q.size() != 0 || s_tvalid || merged_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: the model runs when a bound is first offered; the block takes a bound
    // on a new diagonal and then flushes the old diagonal before inserting it.
    always @(posedge aclk) begin
        bound_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (bound_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                b = bound_q.pop_front();
                merge_bound(b);
                s_tvalid <= 1'b1;
                s_tdata  <= {b.rb, b.lb, b.diag};
                s_tlast  <= b.eoi;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        interval_t want;
        int        hold_left;
        bit        hold_done;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (merged_q.size() == 0) begin
                    report_mismatch("interval with none expected, diag",
                                    m_tdata[FIELD_W-1:0], '0);
                end else begin
                    want = merged_q.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== want.diag)
                        report_mismatch("out_diag", m_tdata[FIELD_W-1:0], want.diag);
                    if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.lb)
                        report_mismatch("out_lb", m_tdata[2*FIELD_W-1:FIELD_W], want.lb);
                    if (m_tdata[3*FIELD_W-1:2*FIELD_W] !== want.rb)
                        report_mismatch("out_rb", m_tdata[3*FIELD_W-1:2*FIELD_W], want.rb);
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_run", FIELD_W'(m_tlast),
                                        FIELD_W'(want.last));
                    if (m_tuser[0] !== want.ovf)
                        report_mismatch("overflow", FIELD_W'(m_tuser[0]),
                                        FIELD_W'(want.ovf));
                end
            end
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn) begin
            quiet = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        set_limit(16'hFFFF);
        send_idle_pct = 23;
        recv_idle_pct = 53;
        // disjoint extremes, then one bound covering both: each widens alone
        push_bound(5, 0, 0, 1'b0);
        push_bound(5, 16'hFFFF, 16'hFFFF, 1'b0);
        push_bound(5, 0, 16'hFFFF, 1'b0);
        push_bound(5, 10, 20, 1'b0);
        // touching edges merge, a gap of one does not
        push_bound(6, 10, 20, 1'b0);
        push_bound(6, 20, 30, 1'b0);
        push_bound(6, 31, 40, 1'b0);
        push_bound(6, 5, 9, 1'b0);
        // reversed bounds
        push_bound(6, 50, 45, 1'b0);
        push_bound(6, 44, 46, 1'b0);
        // lower diagonal flushes as well
        push_bound(3, 1, 2, 1'b0);
        // at the limit: ignored, but end of input still flushes
        push_bound(16'hFFFF, 7, 7, 1'b0);
        push_bound(16'hFFFF, 0, 0, 1'b1);
        // flush of an empty store
        push_bound(16'hFFFF, 1, 1, 1'b1);
        // diagonal change together with end of input: two flushes
        push_bound(20, 1, 1, 1'b0);
        push_bound(20, 3, 4, 1'b0);
        push_bound(21, 2, 2, 1'b1);
        push_bound(16'hFFFE, 16'hAAAA, 16'h5555, 1'b0);
        push_bound(16'hFFFE, 16'h5555, 16'hAAAA, 1'b1);
        drain();

        gen_runs(85, 0, 65535);
        drain();

        send_idle_pct = 53;
        recv_idle_pct = 23;
        set_limit(16'h0000);
        gen_runs(8, 0, 65535);
        drain();

        set_limit(16'd200);
        gen_runs(80, 150, 260);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(16'hFFFF);
        hold_armed = 1'b1;
        gen_runs(85, 0, 3000);
        drain();

        set_limit(FIELD_W'($urandom_range(1000, 65534)));
        gen_runs(50, 0, 65535);
        drain();

        if (mismatches == 0 && merged_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
